// File: hdl/cltpr_pkg.sv
// ----------------------------------------------------------------------------
// cltpr_pkg - shared types and constants of the capacity-limited top-p router
// Field widths, stream packing offsets, register indexes and the result word.
// ----------------------------------------------------------------------------
package cltpr_pkg;

   // field widths
   localparam int CAP_W   = 11;  // capacity register and expert fill count
   localparam int THR_W   = 20;  // threshold, unsigned Q4.16
   localparam int ACC_W   = 20;  // token accumulator, unsigned Q4.16
   localparam int SUM_W   = 21;  // accumulator plus weight, exact
   localparam int WGT_W   = 17;  // weight, unsigned Q1.16
   localparam int TOK_W   = 12;
   localparam int SLOT_W  = 3;
   localparam int EXP_W   = 6;
   localparam int DSLOT_W = 16;
   localparam int DVAL_W  = 13;
   localparam int CSLOT_W = 15;
   localparam int CVAL_W  = 17;
   localparam int PROD_W  = 18;  // expert times capacity plus position

   // batch epoch carried as a tag in every memory word
   localparam int                 EPOCH_W   = 12;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

   // request tdata packing, lowest bit first
   localparam int REQ_NB_LSB   = 0;
   localparam int REQ_TOK_LSB  = 1;
   localparam int REQ_SLOT_LSB = REQ_TOK_LSB + TOK_W;
   localparam int REQ_EXP_LSB  = REQ_SLOT_LSB + SLOT_W;
   localparam int REQ_WGT_LSB  = REQ_EXP_LSB + EXP_W;
   localparam int REQ_BITS     = REQ_WGT_LSB + WGT_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;

   // result word, packed so that accepted lands in bit 0
   typedef struct packed {
      logic [CVAL_W-1:0]  combine_value;
      logic [CSLOT_W-1:0] combine_slot;
      logic [DVAL_W-1:0]  dispatch_value;
      logic [DSLOT_W-1:0] dispatch_slot;
      logic               accepted;
   } rsp_item_type;

   localparam int RSP_BITS    = $bits(rsp_item_type);
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int                   CSR_IDX_W  = 2;
   localparam int                   CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_MODE = 2'd2;

   localparam logic [CAP_W-1:0] CAPACITY_RESET  = 11'd1024;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 20'd65536;

   // output queue
   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 2;

endpackage

// File: hdl/cltpr_bank.sv
// ----------------------------------------------------------------------------
// cltpr_bank - epoch-tagged state memory with read-modify-write forwarding
// One synchronous read port, one write port; stale-epoch words read as zero.
// ----------------------------------------------------------------------------
module cltpr_bank import cltpr_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 11,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   input  logic [EPOCH_W-1:0] cur_epoch,
   output logic [DATA_W-1:0]  rd_value,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0]  wr_data,
   input  logic [EPOCH_W-1:0] wr_epoch,
   input  logic               clr_en,
   input  logic [ADDR_W-1:0]  clr_addr
);

   localparam int WORD_W = EPOCH_W + DATA_W;

   logic [WORD_W-1:0] bank_mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;
   logic [WORD_W-1:0] fwd_word_ff;
   logic [WORD_W-1:0] fwd_word_in;
   logic              fwd_hit_ff;
   logic              fwd_hit_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] word;

   always_comb begin
      mem_we    = wr_en || clr_en;
      mem_addr  = clr_en ? clr_addr : wr_addr;
      mem_wdata = clr_en ? '0 : {wr_epoch, wr_data};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem[mem_addr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_word_ff <= bank_mem[rd_addr];
      end
   end

   // a write landing on the same edge as the read is missed by the read
   always_comb begin
      fwd_hit_in  = rd_en && wr_en && (rd_addr == wr_addr);
      fwd_word_in = {wr_epoch, wr_data};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
      end
      fwd_word_ff <= fwd_word_in;
   end

   always_comb begin
      word     = fwd_hit_ff ? fwd_word_ff : rd_word_ff;
      rd_value = (word[WORD_W-1 -: EPOCH_W] == cur_epoch) ? word[DATA_W-1:0] : '0;
   end

endmodule

// File: hdl/capacity_limited_top_p_expert_router.sv
// ----------------------------------------------------------------------------
// capacity_limited_top_p_expert_router - top-p router with expert capacity
// Accepts routing choices and emits dispatch and combine codes per choice.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one routing choice per transfer; rsp_* returns exactly one
//   result per choice, in order. csr_* writes capacity, threshold and
//   order_mode; write it only while no choice is in flight.
// Throughput: one choice per cycle, set by the single read-modify-write pass
//   over the expert fill memory and the token accumulator memory, while no
//   clearing pass or full queue holds req_tready low; a write issued on the
//   same edge as the next read is forwarded. Each result is decided in stage 1
//   and pushed into the output queue, from which rsp_* presents it.
// Batch clear: new_batch bumps a 12-bit epoch tag instead of clearing the
//   memories; a word with a stale tag reads as zero. Reset, and a new_batch
//   arriving with the epoch at its last value (the 4096th batch start after
//   reset, then every 4095th), run a clearing pass over max(MAX_TOKENS,
//   NUM_EXPERTS) addresses with req_tready low; the latter first waits for the
//   item in flight to drain.
// Stall: a three-entry output queue absorbs results while rsp_tready is low;
//   req_tready drops once the queue plus the item in flight fill it.
// ----------------------------------------------------------------------------
module capacity_limited_top_p_expert_router import cltpr_pkg::*; #(
   parameter int NUM_EXPERTS  = 64,
   parameter int MAX_TOKENS   = 4096,
   parameter int TOP_K        = 8,
   parameter int MAX_CAPACITY = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: new_batch[0], token_pos[12:1], slot_index[15:13],
   //          expert_sel[21:16], weight[38:22], zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // result: accepted[0], dispatch_slot[16:1], dispatch_value[29:17],
   //         combine_slot[44:30], combine_value[61:45], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TOK_AW    = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
   localparam int EXP_AW    = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;
   localparam int CLR_DEPTH = (MAX_TOKENS > NUM_EXPERTS) ? MAX_TOKENS : NUM_EXPERTS;
   localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // ---------------------------------------------------------------- config
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic             order_mode_ff, order_mode_in;  // feeder-side ordering only

   always_comb begin
      capacity_in   = capacity_ff;
      threshold_in  = threshold_ff;
      order_mode_in = order_mode_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY:   capacity_in   = csr_wdata[CAP_W-1:0];
            CSR_THRESHOLD:  threshold_in  = csr_wdata[THR_W-1:0];
            CSR_ORDER_MODE: order_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturate capacity at the memory layout limit
   logic [CAP_W-1:0] cap_eff;
   assign cap_eff = (32'(capacity_ff) > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY) : capacity_ff;

   // ------------------------------------------------------------- request
   logic              req_new_batch;
   logic [TOK_W-1:0]  req_token;
   logic [SLOT_W-1:0] req_slot;
   logic [EXP_W-1:0]  req_expert;
   logic [WGT_W-1:0]  req_weight;
   logic              req_tok_ok;
   logic              req_exp_ok;
   logic              req_accept;

   assign req_new_batch = req_tdata[REQ_NB_LSB];
   assign req_token     = req_tdata[REQ_TOK_LSB +: TOK_W];
   assign req_slot      = req_tdata[REQ_SLOT_LSB +: SLOT_W];
   assign req_expert    = req_tdata[REQ_EXP_LSB +: EXP_W];
   assign req_weight    = req_tdata[REQ_WGT_LSB +: WGT_W];
   assign req_tok_ok    = 32'(req_token) < MAX_TOKENS;
   assign req_exp_ok    = 32'(req_expert) < NUM_EXPERTS;

   // ------------------------------------------------------ control state
   state_type          st_ff, st_in;
   logic [CLR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [EPOCH_W-1:0] item_epoch;
   logic               s1_valid_ff, s1_valid_in;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic               wrap_needed;
   logic               room;
   logic               clr_last;
   logic               push;
   logic               pop;

   assign wrap_needed = req_new_batch && (epoch_ff == EPOCH_MAX);
   assign room        = (32'(fifo_cnt_ff) + 32'(s1_valid_ff)) < FIFO_DEPTH;
   assign req_tready  = (st_ff == ST_RUN) && room && !wrap_needed;
   assign req_accept  = req_tvalid && req_tready;
   assign item_epoch  = req_new_batch ? epoch_ff + 1'b1 : epoch_ff;
   assign clr_last    = clr_cnt_ff == CLR_W'(CLR_DEPTH - 1);

   always_comb begin
      st_in      = st_ff;
      clr_cnt_in = clr_cnt_ff;
      epoch_in   = epoch_ff;
      case (st_ff)
         ST_RUN: begin
            if (req_accept) begin
               epoch_in = item_epoch;
            end
            // epoch exhausted: drain the pipeline, then wipe the memories
            if (req_tvalid && wrap_needed && !s1_valid_ff) begin
               st_in      = ST_CLEAR;
               clr_cnt_in = '0;
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_last) begin
               st_in    = ST_RUN;
               epoch_in = '0;
            end
         end
         default: begin
            st_in = ST_CLEAR;
         end
      endcase
   end

   // ------------------------------------------------- stage 1 registers
   logic                s1_tok_ok_ff, s1_tok_ok_in;
   logic                s1_exp_ok_ff, s1_exp_ok_in;
   logic [WGT_W-1:0]    s1_weight_ff, s1_weight_in;
   logic [DVAL_W-1:0]   s1_tok_p1_ff, s1_tok_p1_in;
   logic [EPOCH_W-1:0]  s1_epoch_ff, s1_epoch_in;
   logic [PROD_W-1:0]   s1_ecap_ff, s1_ecap_in;    // expert * cap
   logic [PROD_W-1:0]   s1_ecap1_ff, s1_ecap1_in;  // expert * (cap + 1)
   logic [CSLOT_W-1:0]  s1_cslot_ff, s1_cslot_in;
   logic [TOK_AW-1:0]   s1_tok_addr_ff, s1_tok_addr_in;
   logic [EXP_AW-1:0]   s1_exp_addr_ff, s1_exp_addr_in;

   always_comb begin
      s1_valid_in    = req_accept;
      s1_tok_ok_in   = req_tok_ok;
      s1_exp_ok_in   = req_exp_ok;
      s1_weight_in   = req_weight;
      s1_tok_p1_in   = DVAL_W'(req_token) + 1'b1;
      s1_epoch_in    = item_epoch;
      s1_ecap_in     = PROD_W'(req_expert) * PROD_W'(cap_eff);
      s1_ecap1_in    = PROD_W'(req_expert) * (PROD_W'(cap_eff) + 1'b1);
      s1_cslot_in    = CSLOT_W'(32'(req_token) * TOP_K + 32'(req_slot));
      s1_tok_addr_in = TOK_AW'(req_token);
      s1_exp_addr_in = EXP_AW'(req_expert);
   end

   // -------------------------------------------------------- state memories
   logic [ACC_W-1:0] tok_value;
   logic [CAP_W-1:0] fill_value;
   logic             tok_wr_en;
   logic [ACC_W-1:0] tok_wr_data;
   logic             exp_wr_en;
   logic [CAP_W-1:0] exp_wr_data;
   logic             clearing;

   assign clearing = st_ff == ST_CLEAR;

   cltpr_bank #(
      .DEPTH  (MAX_TOKENS),
      .DATA_W (ACC_W),
      .ADDR_W (TOK_AW)
   ) u_tok_bank (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept && req_tok_ok),
      .rd_addr   (TOK_AW'(req_token)),
      .cur_epoch (s1_epoch_ff),
      .rd_value  (tok_value),
      .wr_en     (tok_wr_en),
      .wr_addr   (s1_tok_addr_ff),
      .wr_data   (tok_wr_data),
      .wr_epoch  (s1_epoch_ff),
      .clr_en    (clearing && (32'(clr_cnt_ff) < MAX_TOKENS)),
      .clr_addr  (TOK_AW'(clr_cnt_ff))
   );

   cltpr_bank #(
      .DEPTH  (NUM_EXPERTS),
      .DATA_W (CAP_W),
      .ADDR_W (EXP_AW)
   ) u_exp_bank (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept && req_exp_ok),
      .rd_addr   (EXP_AW'(req_expert)),
      .cur_epoch (s1_epoch_ff),
      .rd_value  (fill_value),
      .wr_en     (exp_wr_en),
      .wr_addr   (s1_exp_addr_ff),
      .wr_data   (exp_wr_data),
      .wr_epoch  (s1_epoch_ff),
      .clr_en    (clearing && (32'(clr_cnt_ff) < NUM_EXPERTS)),
      .clr_addr  (EXP_AW'(clr_cnt_ff))
   );

   // ------------------------------------------------------ stage 1 decide
   logic [ACC_W-1:0]  acc;
   logic [CAP_W-1:0]  pos;
   logic [SUM_W-1:0]  sum;
   logic              accept;
   rsp_item_type      s1_result;

   always_comb begin
      acc    = s1_tok_ok_ff ? tok_value : '0;
      pos    = s1_exp_ok_ff ? fill_value : '0;
      sum    = SUM_W'(acc) + SUM_W'(s1_weight_ff);
      accept = s1_tok_ok_ff && s1_exp_ok_ff && (pos < cap_eff) &&
               (sum < SUM_W'(threshold_ff));

      // accumulator always adds, saturating; fill advances only on dispatch
      tok_wr_en   = s1_valid_ff && s1_tok_ok_ff;
      tok_wr_data = sum[SUM_W-1] ? '1 : sum[ACC_W-1:0];
      exp_wr_en   = s1_valid_ff && accept;
      exp_wr_data = pos + 1'b1;

      s1_result.accepted       = accept;
      s1_result.dispatch_slot  = accept ? DSLOT_W'(s1_ecap_ff + PROD_W'(pos)) : '0;
      s1_result.dispatch_value = accept ? s1_tok_p1_ff : '0;
      s1_result.combine_slot   = s1_cslot_ff;
      s1_result.combine_value  = accept ? CVAL_W'(s1_ecap1_ff + PROD_W'(pos) + 1'b1)
                                        : CVAL_W'(s1_ecap1_ff);
   end

   // --------------------------------------------------------- output queue
   rsp_item_type fifo_mem [FIFO_DEPTH];

   assign push       = s1_valid_ff;
   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_TDATA_W'(fifo_mem[rd_ptr_ff]);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fifo_cnt_in = fifo_cnt_ff + 1'b1;
      end else if (pop && !push) begin
         fifo_cnt_in = fifo_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= s1_result;
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAPACITY_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         order_mode_ff <= 1'b0;
         st_ff         <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         epoch_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         fifo_cnt_ff   <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
      end else begin
         capacity_ff   <= capacity_in;
         threshold_ff  <= threshold_in;
         order_mode_ff <= order_mode_in;
         st_ff         <= st_in;
         clr_cnt_ff    <= clr_cnt_in;
         epoch_ff      <= epoch_in;
         s1_valid_ff   <= s1_valid_in;
         fifo_cnt_ff   <= fifo_cnt_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tok_ok_ff   <= s1_tok_ok_in;
      s1_exp_ok_ff   <= s1_exp_ok_in;
      s1_weight_ff   <= s1_weight_in;
      s1_tok_p1_ff   <= s1_tok_p1_in;
      s1_epoch_ff    <= s1_epoch_in;
      s1_ecap_ff     <= s1_ecap_in;
      s1_ecap1_ff    <= s1_ecap1_in;
      s1_cslot_ff    <= s1_cslot_in;
      s1_tok_addr_ff <= s1_tok_addr_in;
      s1_exp_addr_ff <= s1_exp_addr_in;
   end

   // ----------------------------------------------------------- assertions
   // the queue never overflows: a result in flight always has a free entry
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (32'(fifo_cnt_ff) == FIFO_DEPTH)))
      else $error("output queue overflow");

   // a clearing pass never starts with a memory write still pending
   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RUN && st_in == ST_CLEAR) |-> !s1_valid_ff)
      else $error("clearing pass started with an item in flight");

   // the epoch moves only on a batch start or at the end of a clearing pass
   a_epoch_moves: assert property (@(posedge clock) disable iff (reset)
      !$stable(epoch_ff) |->
         $past(req_accept && req_new_batch) || $past(st_ff == ST_CLEAR))
      else $error("epoch changed without a batch start");

   // a dispatched result always carries a nonzero token code
   a_dispatch_code: assert property (@(posedge clock) disable iff (reset)
      (push && s1_result.accepted) |-> (s1_result.dispatch_value != '0))
      else $error("dispatch without token code");

endmodule
